// ----- hw/rtl/ksde_pkg.sv -----
package ksde_pkg;

	localparam int WINDOW_DEPTH = 8;
	localparam int KEY_COUNT = 16;
	localparam int SCAN_W = 16;
	localparam int NOTE_W = 7;
	localparam int FILL_W = $clog2(WINDOW_DEPTH);
	localparam int KIDX_W = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
	localparam logic [NOTE_W-1:0] BASE_NOTE_RESET = NOTE_W'(72);

	typedef logic [KEY_COUNT-1:0] keys_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic start;
		logic step;
		logic emit;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic fire;
		logic bit_hot;
		logic rest_zero;
		logic out_free;
	} sts_t;

	// Keys beyond the scan width always read as released.
	function automatic keys_t scan_to_keys(input logic [SCAN_W-1:0] scan);
		keys_t keys;
		keys = '0;
		for (int i = 0; i < KEY_COUNT; i++) begin
			if (i < SCAN_W) begin
				keys[i] = scan[i];
			end
		end
		return keys;
	endfunction

endpackage

// ----- hw/rtl/key_scan_debounce_events_core.sv -----
// A word that does not complete a uniform window with changes is simply taken.
// A word that completes one walks keys 0 up to the highest changed key, one a cycle,
// and a changed key waits while the output is not free; its event is then registered.
// Throughput: one word per cycle, except after a firing word, which blocks input
// until the highest changed key has been handled.
// Reset clears the fill index, the key state and any pending word; base_note returns to 72.
module key_scan_debounce_events_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [ksde_pkg::NOTE_W-1:0]   cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [ksde_pkg::SCAN_W-1:0]   scan_word,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [ksde_pkg::NOTE_W-1:0]   note,
	output logic                          pressed,
	output logic                          last_event
);
	import ksde_pkg::*;

	cmd_t cmd;
	sts_t sts;

	ksde_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ksde_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.scan_word  (scan_word),
		.out_ready  (out_ready),
		.out_valid  (out_valid),
		.note       (note),
		.pressed    (pressed),
		.last_event (last_event),
		.cmd        (cmd),
		.sts        (sts)
	);

	// An event is never loaded over a word that has not been taken.
	a_emit_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.out_free)
		else $error("event loaded over a pending word");

	// The key walk starts only on an accepted word and then blocks input.
	a_start_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |-> (in_valid && in_ready))
		else $error("key walk started without an accepted word");

	a_start_block: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> !in_ready)
		else $error("input not blocked during key walk");

	// Once the final change is handled, input reopens and that event is marked last.
	a_walk_end: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && sts.rest_zero) |=> (in_ready && out_valid && last_event))
		else $error("key walk did not end on the last event");

endmodule

// ----- hw/rtl/ksde_ctrl.sv -----
module ksde_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  ksde_pkg::sts_t  sts,
	output ksde_pkg::cmd_t  cmd
);
	import ksde_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_SCAN = 1'b1;

	logic state_q;
	logic state_d;

	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		cmd        = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
				if (in_valid && sts.fire) begin
					cmd.start = 1'b1;
					state_d   = ST_SCAN;
				end
			end
			ST_SCAN: begin
				// A key with no change advances freely; a changed key waits for room.
				cmd.step = !sts.bit_hot || sts.out_free;
				cmd.emit = sts.bit_hot && sts.out_free;
				if (cmd.step && sts.rest_zero) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- hw/rtl/ksde_dpath.sv -----
module ksde_dpath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [ksde_pkg::NOTE_W-1:0]   cfg_wdata,
	input  logic [ksde_pkg::SCAN_W-1:0]   scan_word,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic [ksde_pkg::NOTE_W-1:0]   note,
	output logic                          pressed,
	output logic                          last_event,
	input  ksde_pkg::cmd_t                cmd,
	output ksde_pkg::sts_t                sts
);
	import ksde_pkg::*;

	logic [NOTE_W-1:0] base_q;
	logic [FILL_W-1:0] fill_q;
	logic [SCAN_W-1:0] first_q;
	logic              uniform_q;
	keys_t             key_state_q;
	keys_t             diff_q;
	logic [KIDX_W-1:0] k_q;
	logic              out_valid_q;
	logic [NOTE_W-1:0] note_q;
	logic              pressed_q;
	logic              last_q;

	keys_t keys_now;
	keys_t diff_now;
	keys_t bit_k;
	keys_t rest;
	logic  at_end;
	logic  same;

	// The window is uniform exactly when every scan matches the first one.
	assign keys_now = scan_to_keys(scan_word);
	assign diff_now = keys_now ^ key_state_q;
	assign at_end   = (fill_q == FILL_W'(WINDOW_DEPTH - 1));
	assign same     = uniform_q && (scan_word == first_q);
	assign bit_k    = keys_t'(1) << k_q;
	assign rest     = diff_q & ~bit_k;

	assign sts.fire      = at_end && same && (diff_now != '0);
	assign sts.bit_hot   = diff_q[k_q];
	assign sts.rest_zero = (rest == '0);
	assign sts.out_free  = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q      <= BASE_NOTE_RESET;
			fill_q      <= '0;
			uniform_q   <= 1'b0;
			key_state_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				base_q <= cfg_wdata;
			end
			if (cmd.accept) begin
				fill_q <= at_end ? '0 : fill_q + FILL_W'(1);
				if (fill_q == '0) begin
					uniform_q <= 1'b1;
				end else begin
					uniform_q <= same;
				end
			end
			// All changed keys take their new value at once; the events follow.
			if (cmd.start) begin
				key_state_q <= keys_now;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && (fill_q == '0)) begin
			first_q <= scan_word;
		end
		if (cmd.start) begin
			diff_q <= diff_now;
			k_q    <= '0;
		end else if (cmd.step) begin
			diff_q <= rest;
			k_q    <= k_q + KIDX_W'(1);
		end
		if (cmd.emit) begin
			note_q    <= NOTE_W'(base_q + NOTE_W'(k_q));
			pressed_q <= key_state_q[k_q];
			last_q    <= (rest == '0);
		end
	end

	assign out_valid  = out_valid_q;
	assign note       = note_q;
	assign pressed    = pressed_q;
	assign last_event = last_q;

endmodule

// ----- tb/ksde_event_monitor.sv -----
module ksde_event_monitor import ksde_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [NOTE_W-1:0] cfg_wdata,
	input  logic              in_valid,
	input  logic              in_ready,
	input  logic [SCAN_W-1:0] scan_word,
	input  logic              out_valid,
	input  logic              out_ready,
	input  logic [NOTE_W-1:0] note,
	input  logic              pressed,
	input  logic              last_event,
	output int                mismatch_count,
	output int                pending_count,
	output int                events_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [NOTE_W-1:0] note;
		logic              pressed;
		logic              last_event;
	} note_event_t;

	note_event_t       expected_events[$];
	logic [SCAN_W-1:0] window_words[WINDOW_DEPTH];
	int                fill_slot;
	logic [KEY_COUNT-1:0] held_keys;
	logic [NOTE_W-1:0] base_note;

	task automatic report_mismatch(input string what);
		$display("MISMATCH at %0t ns: %s", $time, what);
		mismatch_count++;
	endtask

	// Stores one scan word and, when it closes a uniform window, queues one event
	// per changed key in ascending key order.
	task automatic absorb_scan(input logic [SCAN_W-1:0] word);
		logic [KEY_COUNT-1:0] now_keys;
		logic [KEY_COUNT-1:0] changed;
		note_event_t          ev;
		bit                   uniform;
		int                   top_key;
		window_words[fill_slot] = word;
		fill_slot = (fill_slot == WINDOW_DEPTH - 1) ? 0 : fill_slot + 1;
		if (fill_slot != 0) begin
			return;
		end
		uniform = 1'b1;
		for (int i = 1; i < WINDOW_DEPTH; i++) begin
			if (window_words[i] != window_words[0]) begin
				uniform = 1'b0;
			end
		end
		if (!uniform) begin
			return;
		end
		now_keys = '0;
		for (int k = 0; k < KEY_COUNT; k++) begin
			if (k < SCAN_W) begin
				now_keys[k] = window_words[0][k];
			end
		end
		changed = now_keys ^ held_keys;
		top_key = -1;
		for (int k = 0; k < KEY_COUNT; k++) begin
			if (changed[k]) begin
				top_key = k;
			end
		end
		for (int k = 0; k < KEY_COUNT; k++) begin
			if (changed[k]) begin
				ev.note = NOTE_W'(base_note + k);
				ev.pressed = now_keys[k];
				ev.last_event = (k == top_key);
				expected_events.push_back(ev);
			end
		end
		held_keys = now_keys;
	endtask

	task automatic check_event();
		note_event_t ev;
		if (expected_events.size() == 0) begin
			report_mismatch($sformatf("unexpected event note=%0d pressed=%0b last=%0b",
				note, pressed, last_event));
			return;
		end
		ev = expected_events.pop_front();
		events_checked++;
		if (note != ev.note) begin
			report_mismatch($sformatf("note %0d, expected %0d", note, ev.note));
		end
		if (pressed != ev.pressed) begin
			report_mismatch($sformatf("pressed %0b, expected %0b (note %0d)",
				pressed, ev.pressed, ev.note));
		end
		if (last_event != ev.last_event) begin
			report_mismatch($sformatf("last_event %0b, expected %0b (note %0d)",
				last_event, ev.last_event, ev.note));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_events.delete();
			fill_slot = 0;
			held_keys = '0;
			base_note = BASE_NOTE_RESET;
			mismatch_count = 0;
			events_checked = 0;
			pending_count = 0;
		end else begin
			if (cfg_we) begin
				base_note = cfg_wdata;
			end
			// An event never leaves in the cycle its word is taken, so outputs go first.
			if (out_valid && out_ready) begin
				check_event();
			end
			if (in_valid && in_ready) begin
				absorb_scan(scan_word);
			end
			pending_count = expected_events.size();
		end
	end

endmodule

// ----- tb/tb_key_scan_debounce_events_core.sv -----
module tb_key_scan_debounce_events_core import ksde_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WINDOWS_PER_PHASE = 11;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_we;
	logic [NOTE_W-1:0] cfg_wdata;
	logic              in_valid;
	logic              in_ready;
	logic [SCAN_W-1:0] scan_word;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [NOTE_W-1:0] note;
	logic              pressed;
	logic              last_event;

	int mismatch_count;
	int pending_count;
	int events_checked;
	int tx_idle_pct = 24;
	int rx_idle_pct = 60;
	int words_sent = 0;
	logic [SCAN_W-1:0] key_pattern = '0;

	always #5 clk = ~clk;

	key_scan_debounce_events_core uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.scan_word  (scan_word),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.note       (note),
		.pressed    (pressed),
		.last_event (last_event)
	);

	ksde_event_monitor monitor (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.scan_word      (scan_word),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.note           (note),
		.pressed        (pressed),
		.last_event     (last_event),
		.mismatch_count (mismatch_count),
		.pending_count  (pending_count),
		.events_checked (events_checked)
	);

	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= rx_idle_pct);
	end

	task automatic send_scan(input logic [SCAN_W-1:0] word);
		@(negedge clk);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		scan_word <= word;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
		words_sent++;
	endtask

	// Eight copies of one pattern; a nonzero spoil mask corrupts one slot.
	task automatic send_window(input logic [SCAN_W-1:0] pattern, input int spoil_slot,
		input logic [SCAN_W-1:0] spoil_mask);
		for (int i = 0; i < WINDOW_DEPTH; i++) begin
			send_scan((i == spoil_slot) ? (pattern ^ spoil_mask) : pattern);
		end
	endtask

	// Wait until no event is still expected, then idle with input low to let the block settle.
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_count != 0) begin
			@(negedge clk);
		end
		repeat (24) @(negedge clk);
	endtask

	task automatic write_base(input logic [NOTE_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_window();
		int                pick;
		logic [SCAN_W-1:0] pattern;
		logic [SCAN_W-1:0] flips;
		pick = $urandom_range(99);
		flips = SCAN_W'(1) << $urandom_range(SCAN_W - 1);
		if (pick < 70) begin
			case ($urandom_range(9))
				0: pattern = '0;
				1: pattern = '1;
				2, 3, 4, 5: pattern = key_pattern ^ flips ^ (SCAN_W'(1) << $urandom_range(15));
				9: pattern = key_pattern;
				default: pattern = SCAN_W'($urandom);
			endcase
			send_window(pattern, -1, '0);
			key_pattern = pattern;
		end else if (pick < 88) begin
			pattern = ($urandom_range(1) == 0) ? key_pattern ^ flips : SCAN_W'($urandom);
			if ($urandom_range(1) == 0) begin
				flips = SCAN_W'($urandom) | SCAN_W'(1);
			end
			send_window(pattern, $urandom_range(WINDOW_DEPTH - 1), flips);
		end else begin
			for (int i = 0; i < WINDOW_DEPTH; i++) begin
				send_scan(SCAN_W'($urandom));
			end
		end
	endtask

	initial begin
		logic [NOTE_W-1:0] phase_base;
		logic [NOTE_W-1:0] mid_base;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		scan_word = '0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// With the reset base note: every key goes on, a window spoiled in one slot
		// stays silent, and a repeat of the held pattern changes nothing.
		send_window('1, -1, '0);
		send_window('0, 3, SCAN_W'(1));
		send_window('1, -1, '0);
		key_pattern = '1;
		drain();

		mid_base = NOTE_W'($urandom_range(1, 111));
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					tx_idle_pct = 24;
					rx_idle_pct = 60;
					phase_base = '0;
				end
				1: begin
					tx_idle_pct = 60;
					rx_idle_pct = 24;
					phase_base = NOTE_W'(112);
				end
				2: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
					// Notes past 127 wrap around.
					phase_base = '1;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
					phase_base = mid_base;
				end
			endcase
			write_base(phase_base);
			for (int w = 0; w < WINDOWS_PER_PHASE; w++) begin
				random_window();
			end
			drain();
		end

		$display("Drove %0d scan words in %0d windows and checked %0d note events,",
			words_sent, words_sent / WINDOW_DEPTH, events_checked);
		$display("with base notes 72, 0, 112, 127 and %0d under three idle profiles.",
			mid_base);
		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	initial begin
		#2ms;
		$display("Timeout: %0d events still expected", pending_count);
		$display("Mismatches found");
		$finish;
	end

endmodule

// ----- sim.f -----
hw/rtl/ksde_pkg.sv
hw/rtl/ksde_ctrl.sv
hw/rtl/ksde_dpath.sv
hw/rtl/key_scan_debounce_events_core.sv
tb/ksde_event_monitor.sv
tb/tb_key_scan_debounce_events_core.sv
